// ===== rtl/lacb_pkg.sv =====
// Package for the look-at camera basis block: payload structs, fixed-point
// constants, pipeline depths and the output rounding function.
// No dependencies.
package lacb_pkg;

	localparam int IN_W       = 32;
	localparam int IN_FRAC    = 16;
	localparam int OUT_W      = 16;
	localparam int OUT_FRAC   = 14;
	localparam int UNIT_BITS  = 30;
	localparam int SQ_STEPS   = 32;
	localparam int DIV_STEPS  = UNIT_BITS + 1;
	// mag, byte scan, leading one, shift, square, sum, root, num, divide, sign
	localparam int NORM_LAT   = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;

	localparam logic signed [31:0] NUDGE   = 32'sd107374;   // 1e-4 in Q2.30
	localparam logic signed [31:0] UNIT_ONE = 32'sd1 <<< UNIT_BITS;
	localparam logic [IN_W-1:0]    UP_ONE   = IN_W'(1) << IN_FRAC;

	typedef logic signed [IN_W-1:0]  in_t;
	typedef logic signed [OUT_W-1:0] out_t;
	typedef logic signed [63:0]      wide_t;
	typedef logic signed [31:0]      unit_t;

	typedef struct packed {
		wide_t x;
		wide_t y;
		wide_t z;
	} vec64_t;

	typedef struct packed {
		unit_t x;
		unit_t y;
		unit_t z;
	} vec32_t;

	// sideband that rides along a normalize pipeline
	typedef struct packed {
		vec32_t up;
		vec32_t z;
		logic   up_one;
		logic   redo;
	} side_t;

	typedef struct packed {
		in_t eye_x;
		in_t eye_y;
		in_t eye_z;
		in_t look_x;
		in_t look_y;
		in_t look_z;
		in_t upward_x;
		in_t upward_y;
		in_t upward_z;
	} item_t;

	typedef struct packed {
		out_t right_x;
		out_t right_y;
		out_t right_z;
		out_t head_x;
		out_t head_y;
		out_t head_z;
		out_t back_x;
		out_t back_y;
		out_t back_z;
	} result_t;

	// round half away from zero by sh bits, saturate to 16 bits signed
	function automatic out_t to_out(input wide_t v, input int sh);
		logic [63:0] m;
		logic [63:0] r;
		m = v[63] ? 64'(-v) : 64'(v);
		r = (m + (64'd1 << (sh - 1))) >> sh;
		if (v[63])
			to_out = (r > 64'd32768) ? out_t'(-32768) : out_t'(-r);
		else
			to_out = (r > 64'd32767) ? out_t'(32767) : out_t'(r);
	endfunction

endpackage

// ===== rtl/lacb_normalize.sv =====
// Pipelined vector normalize: scales a 64-bit integer vector to a Q2.30 unit
// vector (block-float shift, square sum, digit-by-digit root, restoring divide).
// Depends on lacb_pkg.
module lacb_normalize import lacb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  vec64_t in_vec,
	input  side_t  in_side,
	output logic   out_valid,
	output vec32_t out_vec,
	output side_t  out_side
);

	localparam int LAST = NORM_LAT - 1;
	localparam int SQ_LAST_IDX = 5 + SQ_STEPS;
	localparam int DV_LAST_IDX = LAST - 1;

	logic [NORM_LAT-1:0] vld_s;
	side_t side_s [NORM_LAT];

	logic signed [63:0] vin [3];

	logic [63:0] mag_s1 [3];
	logic [2:0]  neg_s1;
	logic [63:0] mag_s2 [3];
	logic [2:0]  neg_s2;
	logic [7:0]  bnz_s2;
	logic [2:0]  bpos_s2 [8];
	logic [63:0] mag_s3 [3];
	logic [2:0]  neg_s3;
	logic [5:0]  pos_s3;
	logic        zero_s3;
	logic [29:0] m_s4 [3];
	logic [2:0]  neg_s4;
	logic        zero_s4;
	logic [59:0] sq_s5 [3];
	logic [29:0] m_s5 [3];
	logic [2:0]  neg_s5;
	logic        zero_s5;
	logic [61:0] sum_s6;
	logic [29:0] m_s6 [3];
	logic [2:0]  neg_s6;
	logic        zero_s6;

	logic [63:0] sqn_s [SQ_STEPS];
	logic [63:0] sqr_s [SQ_STEPS];
	logic [29:0] sqm_s [SQ_STEPS][3];
	logic [2:0]  sqneg_s [SQ_STEPS];
	logic        sqz_s [SQ_STEPS];

	logic [60:0] pn_s [3];
	logic [30:0] plen_s;
	logic [2:0]  pneg_s;
	logic        pz_s;

	logic [61:0] dr_s [DIV_STEPS][3];
	logic [30:0] dq_s [DIV_STEPS][3];
	logic [30:0] dl_s [DIV_STEPS];
	logic [2:0]  dneg_s [DIV_STEPS];
	logic        dz_s [DIV_STEPS];

	vec32_t      u_s;

	// combinational next values
	logic [63:0] orv;
	logic [7:0]  bnz_nx;
	logic [2:0]  bpos_nx [8];
	logic [5:0]  pos_nx;
	logic        zero_nx;
	logic [29:0] m_nx [3];
	logic [63:0] sqn_in [SQ_STEPS];
	logic [63:0] sqr_in [SQ_STEPS];
	logic [63:0] sqn_nx [SQ_STEPS];
	logic [63:0] sqr_nx [SQ_STEPS];
	logic [61:0] dr_in [DIV_STEPS][3];
	logic [30:0] dq_in [DIV_STEPS][3];
	logic [30:0] dl_in [DIV_STEPS];
	logic [61:0] dr_nx [DIV_STEPS][3];
	logic [30:0] dq_nx [DIV_STEPS][3];
	vec32_t      u_nx;

	assign vin[0] = in_vec.x;
	assign vin[1] = in_vec.y;
	assign vin[2] = in_vec.z;

	// leading-one search, split into a byte scan and a byte select
	always_comb begin
		orv = mag_s1[0] | mag_s1[1] | mag_s1[2];
		for (int b = 0; b < 8; b++) begin
			bnz_nx[b]  = |orv[8*b +: 8];
			bpos_nx[b] = '0;
			for (int i = 0; i < 8; i++)
				if (orv[8*b + i])
					bpos_nx[b] = 3'(i);
		end
		pos_nx  = '0;
		zero_nx = ~|bnz_s2;
		for (int b = 0; b < 8; b++)
			if (bnz_s2[b])
				pos_nx = {3'(b), bpos_s2[b]};
		// largest magnitude lands in [2^29, 2^30); right shifts truncate
		for (int c = 0; c < 3; c++) begin
			if (pos_s3 >= 6'd29)
				m_nx[c] = 30'(mag_s3[c] >> (pos_s3 - 6'd29));
			else
				m_nx[c] = 30'(mag_s3[c] << (6'd29 - pos_s3));
		end
	end

	// square root, one result bit per stage
	always_comb begin
		logic [63:0] bitv;
		logic [63:0] trial;
		for (int k = 0; k < SQ_STEPS; k++) begin
			if (k == 0) begin
				sqn_in[k] = 64'(sum_s6);
				sqr_in[k] = '0;
			end else begin
				sqn_in[k] = sqn_s[(k == 0) ? 0 : k - 1];
				sqr_in[k] = sqr_s[(k == 0) ? 0 : k - 1];
			end
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			bitv  = 64'd1 << (62 - 2 * k);
			trial = sqr_in[k] + bitv;
			if (sqn_in[k] >= trial) begin
				sqn_nx[k] = sqn_in[k] - trial;
				sqr_nx[k] = (sqr_in[k] >> 1) + bitv;
			end else begin
				sqn_nx[k] = sqn_in[k];
				sqr_nx[k] = sqr_in[k] >> 1;
			end
		end
	end

	// restoring divide, quotient bit 30 down to 0
	always_comb begin
		logic [61:0] dv;
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == 0) begin
				dl_in[k] = plen_s;
				for (int c = 0; c < 3; c++) begin
					dr_in[k][c] = 62'(pn_s[c]);
					dq_in[k][c] = '0;
				end
			end else begin
				dl_in[k] = dl_s[(k == 0) ? 0 : k - 1];
				for (int c = 0; c < 3; c++) begin
					dr_in[k][c] = dr_s[(k == 0) ? 0 : k - 1][c];
					dq_in[k][c] = dq_s[(k == 0) ? 0 : k - 1][c];
				end
			end
		end
		for (int k = 0; k < DIV_STEPS; k++) begin
			dv = 62'(dl_in[k]) << (DIV_STEPS - 1 - k);
			for (int c = 0; c < 3; c++) begin
				if (dr_in[k][c] >= dv) begin
					dr_nx[k][c] = dr_in[k][c] - dv;
					dq_nx[k][c] = dq_in[k][c] | (31'd1 << (DIV_STEPS - 1 - k));
				end else begin
					dr_nx[k][c] = dr_in[k][c];
					dq_nx[k][c] = dq_in[k][c];
				end
			end
		end
	end

	always_comb begin
		unit_t qv [3];
		for (int c = 0; c < 3; c++) begin
			qv[c] = unit_t'({1'b0, dq_s[DIV_STEPS-1][c]});
			if (dneg_s[DIV_STEPS-1][c])
				qv[c] = -qv[c];
		end
		if (dz_s[DIV_STEPS-1]) begin
			u_nx.x = '0;
			u_nx.y = '0;
			u_nx.z = UNIT_ONE;
		end else begin
			u_nx.x = qv[0];
			u_nx.y = qv[1];
			u_nx.z = qv[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NORM_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int j = 1; j < NORM_LAT; j++)
				side_s[j] <= side_s[j-1];

			for (int c = 0; c < 3; c++) begin
				mag_s1[c] <= vin[c][63] ? 64'(-vin[c]) : 64'(vin[c]);
				neg_s1[c] <= vin[c][63];
			end
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			bnz_s2  <= bnz_nx;
			bpos_s2 <= bpos_nx;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			pos_s3  <= pos_nx;
			zero_s3 <= zero_nx;
			m_s4    <= m_nx;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			for (int c = 0; c < 3; c++)
				sq_s5[c] <= m_s4[c] * m_s4[c];
			m_s5    <= m_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			sum_s6  <= 62'(sq_s5[0]) + 62'(sq_s5[1]) + 62'(sq_s5[2]);
			m_s6    <= m_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;

			for (int k = 0; k < SQ_STEPS; k++) begin
				sqn_s[k] <= sqn_nx[k];
				sqr_s[k] <= sqr_nx[k];
			end
			sqm_s[0]   <= m_s6;
			sqneg_s[0] <= neg_s6;
			sqz_s[0]   <= zero_s6;
			for (int k = 1; k < SQ_STEPS; k++) begin
				sqm_s[k]   <= sqm_s[k-1];
				sqneg_s[k] <= sqneg_s[k-1];
				sqz_s[k]   <= sqz_s[k-1];
			end

			// numerator carries the half-divisor rounding term
			for (int c = 0; c < 3; c++)
				pn_s[c] <= 61'({sqm_s[SQ_STEPS-1][c], 30'b0})
					+ 61'(sqr_s[SQ_STEPS-1][30:1]);
			plen_s <= sqr_s[SQ_STEPS-1][30:0];
			pneg_s <= sqneg_s[SQ_STEPS-1];
			pz_s   <= sqz_s[SQ_STEPS-1];

			for (int k = 0; k < DIV_STEPS; k++) begin
				dr_s[k] <= dr_nx[k];
				dq_s[k] <= dq_nx[k];
				dl_s[k] <= dl_in[k];
			end
			dneg_s[0] <= pneg_s;
			dz_s[0]   <= pz_s;
			for (int k = 1; k < DIV_STEPS; k++) begin
				dneg_s[k] <= dneg_s[k-1];
				dz_s[k]   <= dz_s[k-1];
			end

			u_s <= u_nx;
		end
	end

	assign out_valid = vld_s[LAST];
	assign out_vec   = u_s;
	assign out_side  = side_s[LAST];

`ifndef SYNTHESIS
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[3] && !zero_s4 |-> (m_s4[0][29] || m_s4[1][29] || m_s4[2][29]))
		else $error("normalize shift missed target range");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SQ_LAST_IDX] && !sqz_s[SQ_STEPS-1]
			|-> (sqr_s[SQ_STEPS-1][63:31] == '0 && sqr_s[SQ_STEPS-1][30:29] != 2'b00))
		else $error("normalize length out of range");
	a_quot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DV_LAST_IDX] && !dz_s[DIV_STEPS-1]
			|-> (dq_s[DIV_STEPS-1][0] <= 31'(UNIT_ONE) && dq_s[DIV_STEPS-1][1] <= 31'(UNIT_ONE)
				&& dq_s[DIV_STEPS-1][2] <= 31'(UNIT_ONE)))
		else $error("normalize component above one");
`endif

endmodule

// ===== rtl/look_at_camera_basis.sv =====
// Look-at camera basis: right, head and back unit axes in Q2.14 from eye,
// target and up in Q16.16. Depends on lacb_pkg and lacb_normalize.
//
//  channel  direction  handshake                      payload
//  item     in         item_valid / item_ready        item_t   (eye, look, upward)
//  result   out        result_valid / result_ready    result_t (right, head, back)
//
// One item enters per cycle while item_ready is high; three normalize pipelines
// run in series (square root and divide one bit a stage).
// Reset clears only the valid bits; nothing is kept between items.
// A stall on the result side freezes the whole pipeline in place.
module look_at_camera_basis import lacb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	typedef struct packed {
		wide_t a0;
		wide_t a1;
		wide_t b0;
		wide_t b1;
		wide_t c0;
		wide_t c1;
	} prod_t;

	function automatic prod_t xprod(input vec32_t a, input vec32_t b);
		xprod.a0 = a.y * b.z;
		xprod.a1 = a.z * b.y;
		xprod.b0 = a.z * b.x;
		xprod.b1 = a.x * b.z;
		xprod.c0 = a.x * b.y;
		xprod.c1 = a.y * b.x;
	endfunction

	function automatic vec64_t xdiff(input prod_t p);
		xdiff.x = p.a0 - p.a1;
		xdiff.y = p.b0 - p.b1;
		xdiff.z = p.c0 - p.c1;
	endfunction

	logic en;

	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	vec64_t d_s1;
	side_t  side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	prod_t  pr_s2, pr_s5, pr_s7;
	vec64_t zn_s3, raw_s6, y_s8;
	vec32_t x_s7, z_s7, x_s8, z_s8;
	result_t result_s9;

	logic   n1_valid, n2_valid, n3_valid;
	vec32_t n1_vec, n2_vec, n3_vec;
	side_t  n1_side, n2_side, n3_side;

	vec64_t raw1;
	side_t  side_in;

	assign en         = !vld_s9 || result_ready;
	assign item_ready = en;

	always_comb begin
		side_in.up.x   = item.upward_x;
		side_in.up.y   = item.upward_y;
		side_in.up.z   = item.upward_z;
		side_in.z      = '0;
		side_in.up_one = (item.upward_z[IN_W-1] ? IN_W'(-item.upward_z)
			: IN_W'(item.upward_z)) == UP_ONE;
		side_in.redo   = 1'b0;
	end

	assign raw1 = xdiff(pr_s2);

	lacb_normalize u_norm_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_vec    (d_s1),
		.in_side   (side_s1),
		.out_valid (n1_valid),
		.out_vec   (n1_vec),
		.out_side  (n1_side)
	);

	lacb_normalize u_norm_nudge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_vec    (zn_s3),
		.in_side   (side_s3),
		.out_valid (n2_valid),
		.out_vec   (n2_vec),
		.out_side  (n2_side)
	);

	lacb_normalize u_norm_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_vec    (raw_s6),
		.in_side   (side_s6),
		.out_valid (n3_valid),
		.out_vec   (n3_vec),
		.out_side  (n3_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= '0;
			{vld_s6, vld_s7, vld_s8, vld_s9} <= '0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= n1_valid;
			vld_s3 <= vld_s2;
			vld_s4 <= n2_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= n3_valid;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.x  <= wide_t'(item.eye_x) - wide_t'(item.look_x);
			d_s1.y  <= wide_t'(item.eye_y) - wide_t'(item.look_y);
			d_s1.z  <= wide_t'(item.eye_z) - wide_t'(item.look_z);
			side_s1 <= side_in;

			// first cross only decides whether back needs the nudge
			pr_s2   <= xprod(n1_side.up, n1_vec);
			side_s2 <= '{up: n1_side.up, z: n1_vec, up_one: n1_side.up_one,
				redo: n1_side.redo};

			side_s3 <= '{up: side_s2.up, z: side_s2.z, up_one: side_s2.up_one,
				redo: (raw1.x == '0) && (raw1.y == '0) && (raw1.z == '0)};
			zn_s3.x <= wide_t'(side_s2.up_one ? side_s2.z.x + NUDGE : side_s2.z.x);
			zn_s3.y <= wide_t'(side_s2.z.y);
			zn_s3.z <= wide_t'(side_s2.up_one ? side_s2.z.z : side_s2.z.z + NUDGE);

			side_s4 <= '{up: n2_side.up, z: (n2_side.redo ? n2_vec : n2_side.z),
				up_one: n2_side.up_one, redo: n2_side.redo};

			pr_s5   <= xprod(side_s4.up, side_s4.z);
			side_s5 <= side_s4;

			raw_s6  <= xdiff(pr_s5);
			side_s6 <= side_s5;

			pr_s7 <= xprod(n3_side.z, n3_vec);
			x_s7  <= n3_vec;
			z_s7  <= n3_side.z;

			y_s8 <= xdiff(pr_s7);
			x_s8 <= x_s7;
			z_s8 <= z_s7;

			result_s9.right_x <= to_out(wide_t'(x_s8.x), UNIT_BITS - OUT_FRAC);
			result_s9.right_y <= to_out(wide_t'(x_s8.y), UNIT_BITS - OUT_FRAC);
			result_s9.right_z <= to_out(wide_t'(x_s8.z), UNIT_BITS - OUT_FRAC);
			result_s9.head_x  <= to_out(y_s8.x, 2 * UNIT_BITS - OUT_FRAC);
			result_s9.head_y  <= to_out(y_s8.y, 2 * UNIT_BITS - OUT_FRAC);
			result_s9.head_z  <= to_out(y_s8.z, 2 * UNIT_BITS - OUT_FRAC);
			result_s9.back_x  <= to_out(wide_t'(z_s8.x), UNIT_BITS - OUT_FRAC);
			result_s9.back_y  <= to_out(wide_t'(z_s8.y), UNIT_BITS - OUT_FRAC);
			result_s9.back_z  <= to_out(wide_t'(z_s8.z), UNIT_BITS - OUT_FRAC);
		end
	end

	assign result_valid = vld_s9;
	assign result       = result_s9;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8}))
		else $error("pipeline valid moved during stall");
	a_back_unit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.back_x != '0 || result.back_y != '0 || result.back_z != '0))
		else $error("back axis is zero");
	a_right_unit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.right_x != '0 || result.right_y != '0 || result.right_z != '0))
		else $error("right axis is zero");
`endif

endmodule
